// File: design/hcc_pkg.sv
// Shared types and constants for the IPv6 header chain checker.
`timescale 1ns / 1ps
`default_nettype none

package hcc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 32;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CNT_W-1:0] FIXED_LEN = 32'd40;
  localparam logic [BYTE_W-1:0] JUMBO_OPT = 8'hC2;

  typedef enum logic [1:0] {
    PH_FIXED,
    PH_EXT,
    PH_PAYLOAD,
    PH_STOP
  } phase_e;

  typedef enum logic [2:0] {
    VD_OK,
    VD_SHORT,
    VD_VERSION,
    VD_HOPLIMIT,
    VD_PARAM,
    VD_RT0
  } verdict_e;

  // Jumbo tracking: none required, required but not seen, accepted, being read
  typedef enum logic [1:0] {
    JB_NONE,
    JB_NEEDED,
    JB_OK,
    JB_READING
  } jumbo_e;

  // One packet byte handed to the chain walker
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [BYTE_W-1:0] data;
  } step_t;

  // Parser state after the last byte of a packet
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  stated_length;
    logic [CNT_W-1:0]  header_start;
    logic [BYTE_W-1:0] current_type;
    jumbo_e            jumbo;
    verdict_e          first_error;
    phase_e            phase;
  } snap_t;

endpackage

`default_nettype wire

// File: design/ipv6_header_chain_checker_unit.sv
// A packet's verdict passes the input, snapshot and result registers before m_axis_tvalid.
// Throughput: one byte per cycle between stalls; the per-byte parse step and
// the verdict stage are each one register-to-register pass.
// A stalled result holds the verdict register; the byte input keeps flowing
// until the next packet end needs the full result path.
// Reset clears all control and parse state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_header_chain_checker_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata    // [2:0] verdict, [10:3] next_header,
                                           // [42:11] payload_offset,
                                           // [74:43] payload_length, [79:75] zero
);
  import hcc_pkg::*;

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_data_q;
  logic              in_last_q;
  logic              advance;
  logic              snap_ready;
  step_t             step;
  snap_t             snap;
  verdict_e          verdict;
  logic [7:0]        next_header;
  logic [31:0]       payload_offset;
  logic [31:0]       payload_length;

  // hold a final byte until the verdict stage can take its snapshot
  assign advance       = in_valid_q && (!in_last_q || snap_ready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  assign step = '{valid: advance, last: in_last_q, data: in_data_q};

  hcc_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (step),
    .snap_o (snap)
  );

  hcc_verdict u_verdict (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .snap_valid_i     (advance && in_last_q),
    .snap_ready_o     (snap_ready),
    .snap_i           (snap),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .verdict_o        (verdict),
    .next_header_o    (next_header),
    .payload_offset_o (payload_offset),
    .payload_length_o (payload_length)
  );

  assign m_axis_tdata = {5'd0, payload_length, payload_offset, next_header, verdict};

endmodule

`default_nettype wire

// File: design/hcc_walk.sv
// Per-byte walk over the fixed header and the extension header chain.
`timescale 1ns / 1ps
`default_nettype none

module hcc_walk (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hcc_pkg::step_t item_i,
  output hcc_pkg::snap_t     snap_o
);
  import hcc_pkg::*;

  function automatic logic is_ext(input logic [BYTE_W-1:0] t);
    is_ext = (t == 8'd0) || (t == 8'd43) || (t == 8'd51) || (t == 8'd60) ||
             (t == 8'd135) || (t == 8'd139) || (t == 8'd140);
  endfunction

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  stated_q, stated_d;
  logic [CNT_W-1:0]  hs_q, hs_d;
  logic [CNT_W-1:0]  he_q, he_d;
  logic [BYTE_W-1:0] cur_q, cur_d;
  logic [BYTE_W-1:0] nt_q, nt_d;
  jumbo_e            jumbo_q, jumbo_d;
  verdict_e          fe_q, fe_d;
  phase_e            phase_q, phase_d;

  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  rel;
  logic [CNT_W:0]    end_sum;
  logic [CNT_W:0]    pos_inc;
  logic [CNT_W-1:0]  jumbo_len;
  logic [BYTE_W-1:0] b;
  logic              failed;

  assign pos     = count_q;
  assign b       = item_i.data;
  assign rel     = pos - hs_q;
  assign pos_inc = {1'b0, pos} + {{CNT_W{1'b0}}, 1'b1};
  assign end_sum = {1'b0, hs_q} + {{(CNT_W-BYTE_W-2){1'b0}}, b, 3'b000} +
                   (CNT_W+1)'(8);
  assign jumbo_len = {stated_q[CNT_W-BYTE_W-1:0], b};

  always_comb begin
    count_d  = (pos == COUNT_MAX) ? pos : pos_inc[CNT_W-1:0];
    stated_d = stated_q;
    hs_d     = hs_q;
    he_d     = he_q;
    cur_d    = cur_q;
    nt_d     = nt_q;
    jumbo_d  = jumbo_q;
    fe_d     = fe_q;
    phase_d  = phase_q;
    failed   = 1'b0;

    case (phase_q)
      PH_FIXED: begin
        if (pos == 32'd0 && b[7:4] != 4'd6 && fe_q == VD_OK) begin
          fe_d = VD_VERSION;
        end else if (pos == 32'd4) begin
          stated_d = {16'd0, b, 8'd0};
        end else if (pos == 32'd5) begin
          stated_d = stated_q | {24'd0, b};
        end else if (pos == 32'd6) begin
          cur_d = b;
        end else if (pos == 32'd7 && b == 8'd0 && fe_q == VD_OK) begin
          fe_d = VD_HOPLIMIT;
        end else if (pos == 32'd39) begin
          jumbo_d = (stated_q == '0) ? JB_NEEDED : JB_NONE;
          hs_d    = FIXED_LEN;
          he_d    = FIXED_LEN;
          if (fe_q != VD_OK) begin
            phase_d = PH_STOP;
          end else begin
            phase_d = is_ext(cur_q) ? PH_EXT : PH_PAYLOAD;
          end
        end
      end
      PH_EXT: begin
        if (rel == 32'd0) begin
          nt_d = b;
        end else if (rel == 32'd1) begin
          he_d = end_sum[CNT_W] ? COUNT_MAX : end_sum[CNT_W-1:0];
        end else if (rel == 32'd2) begin
          if (cur_q == 8'd0 && b == JUMBO_OPT) begin
            if (jumbo_q != JB_NEEDED) begin
              failed = 1'b1;
              if (fe_q == VD_OK) fe_d = VD_PARAM;
            end else begin
              jumbo_d  = JB_READING;
              stated_d = '0;
            end
          end else if (cur_q == 8'd43 && b == 8'd0) begin
            failed = 1'b1;
            if (fe_q == VD_OK) fe_d = VD_RT0;
          end
        end else if (rel >= 32'd4 && rel <= 32'd7 && jumbo_q == JB_READING) begin
          stated_d = jumbo_len;
          if (rel == 32'd7) begin
            if (jumbo_len <= 32'd65535) begin
              failed = 1'b1;
              if (fe_q == VD_OK) fe_d = VD_PARAM;
            end else begin
              jumbo_d = JB_OK;
            end
          end
        end
        if (failed) begin
          phase_d = PH_STOP;
        end else if (rel >= 32'd7 && pos_inc == {1'b0, he_q}) begin
          // end of this extension header: step to the next one
          hs_d  = he_q;
          cur_d = nt_q;
          if (!is_ext(nt_q)) phase_d = PH_PAYLOAD;
        end
      end
      default: begin
      end
    endcase
  end

  assign snap_o = '{count: count_d, stated_length: stated_d, header_start: hs_d,
                    current_type: cur_d, jumbo: jumbo_d, first_error: fe_d,
                    phase: phase_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      stated_q <= '0;
      hs_q     <= '0;
      he_q     <= '0;
      cur_q    <= '0;
      nt_q     <= '0;
      jumbo_q  <= JB_NONE;
      fe_q     <= VD_OK;
      phase_q  <= PH_FIXED;
    end else if (item_i.valid) begin
      if (item_i.last) begin
        // packet done: back to the start state
        count_q  <= '0;
        stated_q <= '0;
        hs_q     <= '0;
        he_q     <= '0;
        cur_q    <= '0;
        nt_q     <= '0;
        jumbo_q  <= JB_NONE;
        fe_q     <= VD_OK;
        phase_q  <= PH_FIXED;
      end else begin
        count_q  <= count_d;
        stated_q <= stated_d;
        hs_q     <= hs_d;
        he_q     <= he_d;
        cur_q    <= cur_d;
        nt_q     <= nt_d;
        jumbo_q  <= jumbo_d;
        fe_q     <= fe_d;
        phase_q  <= phase_d;
      end
    end
  end

  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.last |=> count_q == '0 && phase_q == PH_FIXED &&
    fe_q == VD_OK)
    else $error("state not cleared after last item");

  a_fixed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FIXED |-> hs_q == '0 && jumbo_q == JB_NONE)
    else $error("chain state set during fixed header");

  a_ext_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_EXT |-> fe_q == VD_OK)
    else $error("chain walk continues after an error");

endmodule

`default_nettype wire

// File: design/hcc_verdict.sv
// Snapshot register, verdict decision and result register.
`timescale 1ns / 1ps
`default_nettype none

module hcc_verdict (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           snap_valid_i,
  output logic                snap_ready_o,
  input  wire hcc_pkg::snap_t snap_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output hcc_pkg::verdict_e   verdict_o,
  output logic [7:0]          next_header_o,
  output logic [31:0]         payload_offset_o,
  output logic [31:0]         payload_length_o
);
  import hcc_pkg::*;

  logic              snap_valid_q;
  snap_t             snap_q;
  logic              out_valid_q;
  verdict_e          verdict_q, verdict_d;
  logic [BYTE_W-1:0] nh_q, nh_d;
  logic [CNT_W-1:0]  off_q, off_d;
  logic [CNT_W-1:0]  len_q, len_d;

  logic              out_load;
  logic [CNT_W:0]    need;
  logic              too_big;
  logic [CNT_W-1:0]  hlen;

  assign out_load     = !out_valid_q || out_ready_i;
  assign snap_ready_o = !snap_valid_q || out_load;

  assign need    = {1'b0, snap_q.stated_length} + {1'b0, FIXED_LEN};
  assign too_big = need > {1'b0, snap_q.count};
  assign hlen    = snap_q.header_start - FIXED_LEN;

  always_comb begin
    if (snap_q.count < FIXED_LEN) begin
      verdict_d = VD_SHORT;
    end else if (snap_q.first_error == VD_VERSION || snap_q.first_error == VD_HOPLIMIT) begin
      verdict_d = snap_q.first_error;
    end else if ((snap_q.jumbo == JB_NONE || snap_q.jumbo == JB_OK) && too_big) begin
      verdict_d = VD_PARAM;
    end else if (snap_q.first_error != VD_OK) begin
      verdict_d = snap_q.first_error;
    end else if (snap_q.phase != PH_PAYLOAD) begin
      verdict_d = VD_PARAM;
    end else if (snap_q.jumbo != JB_NONE && snap_q.jumbo != JB_OK) begin
      verdict_d = VD_PARAM;
    end else begin
      verdict_d = VD_OK;
    end

    nh_d  = '0;
    off_d = '0;
    len_d = '0;
    if (verdict_d == VD_OK) begin
      nh_d  = snap_q.current_type;
      off_d = snap_q.header_start;
      len_d = (snap_q.stated_length >= hlen) ? snap_q.stated_length - hlen
                                             : snap_q.stated_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (snap_ready_o) snap_valid_q <= snap_valid_i;
      if (out_load) out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_ready_o && snap_valid_i) snap_q <= snap_i;
    if (out_load && snap_valid_q) begin
      verdict_q <= verdict_d;
      nh_q      <= nh_d;
      off_q     <= off_d;
      len_q     <= len_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign next_header_o    = nh_q;
  assign payload_offset_o = off_q;
  assign payload_length_o = len_q;

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && verdict_q != VD_OK |-> nh_q == '0 && off_q == '0 && len_q == '0)
    else $error("fields not cleared on a failing verdict");

  a_ok_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && verdict_q == VD_OK |-> off_q >= FIXED_LEN)
    else $error("payload offset inside the fixed header");

endmodule

`default_nettype wire
